FILE: src/uaru_pkg.sv
// Package for the angle response unwrapper: opcodes, parse phases and the
// turn constants used by the unwrap logic. No dependencies.
`default_nettype none

package uaru_pkg;

    // Heading counts in one full turn of the sensor.
    localparam int COUNTS_PER_TURN = 5760;

    localparam logic [15:0] TURN_COUNT   = 16'(COUNTS_PER_TURN);
    localparam logic [15:0] LOW_QUARTER  = 16'(COUNTS_PER_TURN / 4);
    localparam logic [15:0] HIGH_QUARTER = 16'((3 * COUNTS_PER_TURN) / 4);

    // Second header byte of a good response: the data length.
    localparam logic [7:0] DATA_LENGTH = 8'd2;

    // Reset value of the success code register.
    localparam logic [7:0] SUCCESS_CODE_RESET = 8'd187;

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_ARM    = 2'd1,
        OP_REZERO = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_DATA   = 3'b100
    } t_phase;

    typedef enum logic {
        ST_SAMPLE = 1'b0,
        ST_REJECT = 1'b1
    } t_status;

endpackage

`default_nettype wire

FILE: src/uart_angle_response_unwrapper_core.sv
// A word is taken into the input register; the result register loads from it
// when the word advances. Throughput: one word per cycle, stalls only when the
// result register is full and not taken. Sync active-low reset returns the
// parser to idle, clears the zero point and samples, and restores the success
// code to its default. Depends on uaru_pkg.
`default_nettype none

module uart_angle_response_unwrapper_core
    import uaru_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_rx_byte,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_status,
    output logic signed [31:0] o_angle_count
);

    logic [7:0]  r_success_code;

    // Input register.
    logic        r_in_valid;
    logic [1:0]  r_opcode;
    logic [7:0]  r_rx_byte;

    // Parser and unwrap state.
    t_phase      r_phase,    n_phase;
    logic        r_byte_idx, n_byte_idx;
    logic [7:0]  r_low_hold, n_low_hold;
    logic [15:0] r_cur,      n_cur;
    logic [15:0] r_prev,     n_prev;
    logic [31:0] r_offset,   n_offset;
    logic        r_have_first, n_have_first;

    // Result register.
    logic        r_out_valid;
    logic        r_status,  n_status;
    logic [31:0] r_count,   n_count;
    logic        n_emit;

    logic        advance;
    logic [15:0] sample;
    logic        wrap_dn;
    logic        wrap_up;
    logic [31:0] delta;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign sample  = {r_rx_byte, r_low_hold};
    assign wrap_dn = (r_prev > HIGH_QUARTER) && (sample < LOW_QUARTER);
    assign wrap_up = (r_prev < LOW_QUARTER) && (sample > HIGH_QUARTER);

    always_comb begin
        if (wrap_dn) begin
            delta = -{16'd0, TURN_COUNT};
        end else if (wrap_up) begin
            delta = {16'd0, TURN_COUNT};
        end else begin
            delta = 32'd0;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_byte_idx   = r_byte_idx;
        n_low_hold   = r_low_hold;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_offset     = r_offset;
        n_have_first = r_have_first;
        n_emit       = 1'b0;
        n_status     = ST_SAMPLE;
        n_count      = 32'd0;

        case (t_opcode'(r_opcode))
            OP_ARM: begin
                n_phase    = PH_HEADER;
                n_byte_idx = 1'b0;
            end
            OP_REZERO: begin
                n_offset = {16'd0, r_cur};
            end
            OP_BYTE: begin
                if (r_phase == PH_HEADER || r_phase == PH_DATA) begin
                    if (!r_byte_idx) begin
                        n_low_hold = r_rx_byte;
                        n_byte_idx = 1'b1;
                    end else begin
                        n_byte_idx = 1'b0;
                        if (r_phase == PH_HEADER) begin
                            if (r_low_hold == r_success_code && r_rx_byte == DATA_LENGTH) begin
                                n_phase = PH_DATA;
                            end else begin
                                n_phase  = PH_IDLE;
                                n_emit   = 1'b1;
                                n_status = ST_REJECT;
                            end
                        end else begin
                            n_cur   = sample;
                            n_prev  = sample;
                            n_phase = PH_IDLE;
                            n_emit  = 1'b1;
                            // The very first sample becomes the zero point, so it reads zero.
                            if (r_have_first) begin
                                n_offset = r_offset + delta;
                                n_count  = r_offset + delta - {16'd0, sample};
                            end else begin
                                n_offset     = {16'd0, sample};
                                n_have_first = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_success_code <= SUCCESS_CODE_RESET;
        end else if (i_cfg_we) begin
            r_success_code <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_opcode  <= i_opcode;
            r_rx_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_byte_idx   <= 1'b0;
            r_low_hold   <= 8'd0;
            r_cur        <= 16'd0;
            r_prev       <= 16'd0;
            r_offset     <= 32'd0;
            r_have_first <= 1'b0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_byte_idx   <= n_byte_idx;
            r_low_hold   <= n_low_hold;
            r_cur        <= n_cur;
            r_prev       <= n_prev;
            r_offset     <= n_offset;
            r_have_first <= n_have_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_emit) begin
            r_status <= n_status;
            r_count  <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_angle_count = r_count;

`ifndef SYNTHESIS
    // A rejected header always reports a zero count.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_angle_count == 32'd0)
        else $error("rejection word with nonzero count");

    // Once a sample has been taken, the first-sample flag never clears.
    a_first_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_first |=> r_have_first)
        else $error("first-sample flag cleared");

    // The first sample ever taken reads zero and sets the flag.
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_emit && n_status == ST_SAMPLE && !r_have_first
        |=> o_out_valid && o_angle_count == 32'd0 && r_have_first)
        else $error("first sample not zero");

    // Every word that produces a result leaves the parser idle.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_emit |=> r_phase == PH_IDLE && !r_byte_idx)
        else $error("parser not idle after result");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for uart_angle_response_unwrapper_core: queued words drive the
// response parser, and an in-bench tracker of the header, data and turn unwrap logic
// predicts every result. Depends on uaru_pkg and the core.

module testbench
    import uaru_pkg::*;
();

    typedef struct {
        t_opcode    opcode;
        logic [7:0] rx;
    } t_serial_word;

    typedef struct {
        t_status            status;
        logic signed [31:0] angle;
    } t_angle_report;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_opcode     in_opcode = OP_BYTE;
    logic [7:0]  in_rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        out_status;
    logic signed [31:0] out_angle;

    t_serial_word  pending_words[$];
    t_angle_report expected_reports[$];
    t_serial_word  next_word;
    t_angle_report head_report;
    int unsigned   send_gap_pct = 18;
    int unsigned   recv_stall_pct = 74;
    int unsigned   fail_count = 0;

    // Tracker copy of the parser, the unwrap state and the success code.
    logic [7:0]  programmed_code = SUCCESS_CODE_RESET;
    t_phase      parse_state = PH_IDLE;
    logic        pair_upper = 1'b0;
    logic [7:0]  held_byte = 8'h00;
    logic [15:0] last_heading = 16'h0000;
    logic [15:0] prior_heading = 16'h0000;
    logic [31:0] tracked_offset = 32'h0000_0000;
    logic        heading_seen = 1'b0;

    uart_angle_response_unwrapper_core DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_opcode     (in_opcode),
        .i_rx_byte    (in_rx_byte),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (out_status),
        .o_angle_count(out_angle)
    );

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic void track_response_word(t_opcode op, logic [7:0] rx);
        t_angle_report rep;
        case (op)
            OP_ARM: begin
                parse_state = PH_HEADER;
                pair_upper = 1'b0;
            end
            OP_REZERO: tracked_offset = {16'h0000, last_heading};
            OP_BYTE: begin
                if (parse_state == PH_HEADER || parse_state == PH_DATA) begin
                    if (!pair_upper) begin
                        held_byte = rx;
                        pair_upper = 1'b1;
                    end else begin
                        pair_upper = 1'b0;
                        if (parse_state == PH_HEADER) begin
                            if (held_byte == programmed_code && rx == DATA_LENGTH) begin
                                parse_state = PH_DATA;
                            end else begin
                                parse_state = PH_IDLE;
                                rep.status = ST_REJECT;
                                rep.angle = 32'sd0;
                                expected_reports.push_back(rep);
                            end
                        end else begin
                            last_heading = {rx, held_byte};
                            // A jump between the outer quarters of a turn moves the zero point.
                            if (prior_heading > HIGH_QUARTER && last_heading < LOW_QUARTER) begin
                                tracked_offset = tracked_offset - {16'h0000, TURN_COUNT};
                            end else if (prior_heading < LOW_QUARTER &&
                                         last_heading > HIGH_QUARTER) begin
                                tracked_offset = tracked_offset + {16'h0000, TURN_COUNT};
                            end
                            prior_heading = last_heading;
                            if (!heading_seen) begin
                                tracked_offset = {16'h0000, last_heading};
                                heading_seen = 1'b1;
                            end
                            parse_state = PH_IDLE;
                            rep.status = ST_SAMPLE;
                            rep.angle = tracked_offset - {16'h0000, last_heading};
                            expected_reports.push_back(rep);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Driver: a word is taken at each edge with valid and ready high.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                track_response_word(in_opcode, in_rx_byte);
            end
            if (!in_valid || in_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_word = pending_words.pop_front();
                    in_opcode <= next_word.opcode;
                    in_rx_byte <= next_word.rx;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares every accepted result with the oldest prediction.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result with nothing expected: status %0d, angle_count %0d",
                           out_status, out_angle);
                    fail_count++;
                end else begin
                    head_report = expected_reports.pop_front();
                    if (out_status !== head_report.status) begin
                        $error("status: expected %0d, got %0d", head_report.status, out_status);
                        fail_count++;
                    end
                    if (out_angle !== head_report.angle) begin
                        $error("angle_count: expected %0d, got %0d",
                               head_report.angle, out_angle);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_word(input t_opcode op, input logic [7:0] rx);
        t_serial_word w;
        w.opcode = op;
        w.rx = rx;
        pending_words.push_back(w);
    endtask

    task automatic push_response(input logic [7:0] code, input logic [15:0] heading);
        push_word(OP_ARM, 8'($urandom));
        push_word(OP_BYTE, code);
        push_word(OP_BYTE, DATA_LENGTH);
        push_word(OP_BYTE, heading[7:0]);
        push_word(OP_BYTE, heading[15:8]);
    endtask

    // Waits until every word is sent and every result is back, then lets the
    // pipeline empty of words that produce nothing.
    task automatic settle_pipeline();
        while (pending_words.size() != 0 || in_valid || expected_reports.size() != 0) begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic queue_random_words(input int unsigned target, input logic [7:0] code);
        int unsigned counted;
        int unsigned pick;
        logic [15:0] heading;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                // Headings cluster in the outer quarters so that turns get crossed.
                case ($urandom_range(6))
                    0, 1: heading = 16'($urandom_range(LOW_QUARTER - 1));
                    2, 3: heading = 16'($urandom_range(TURN_COUNT - 1, HIGH_QUARTER + 1));
                    4: heading = 16'($urandom);
                    5: heading = $urandom_range(1) ? LOW_QUARTER : HIGH_QUARTER;
                    default: heading = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                endcase
                push_response(code, heading);
                counted += 5;
            end else if (pick < 75) begin
                push_word(OP_REZERO, 8'($urandom));
                counted += 1;
            end else if (pick < 85) begin
                // A header that usually fails the code check, the length check or both.
                push_word(OP_ARM, 8'($urandom));
                push_word(OP_BYTE, $urandom_range(1) ? code : 8'($urandom));
                push_word(OP_BYTE, $urandom_range(1) ? DATA_LENGTH : 8'($urandom_range(3)));
                counted += 3;
            end else if (pick < 93) begin
                push_word(t_opcode'($urandom_range(3)), 8'($urandom));
                counted += 1;
            end else begin
                // A response cut off after one data byte; what follows decides its fate.
                push_word(OP_ARM, 8'($urandom));
                push_word(OP_BYTE, code);
                push_word(OP_BYTE, DATA_LENGTH);
                push_word(OP_BYTE, 8'($urandom));
                counted += 4;
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] code, input int unsigned gap_pct,
                             input int unsigned stall_pct);
        settle_pipeline();
        cfg_we <= 1'b1;
        cfg_data <= code;
        programmed_code = code;
        @(posedge clk);
        cfg_we <= 1'b0;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        queue_random_words(80, code);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset success code.
        push_word(OP_BYTE, 8'h55);
        push_word(OP_UNUSED, 8'hFF);
        push_word(OP_REZERO, 8'h00);
        push_response(SUCCESS_CODE_RESET, 16'hFFFF);
        push_response(SUCCESS_CODE_RESET, 16'h0000);
        push_word(OP_ARM, 8'h00);
        push_word(OP_BYTE, 8'h00);
        push_word(OP_BYTE, DATA_LENGTH);
        push_word(OP_ARM, 8'hFF);
        push_word(OP_BYTE, SUCCESS_CODE_RESET);
        push_word(OP_BYTE, 8'h03);
        push_word(OP_REZERO, 8'hAA);
        push_word(OP_ARM, 8'h00);
        push_word(OP_BYTE, SUCCESS_CODE_RESET);
        push_response(SUCCESS_CODE_RESET, 16'h0140);

        run_phase(8'h00, 18, 74);
        run_phase(8'hFF, 74, 18);
        run_phase(8'($urandom), 74, 18);
        run_phase(SUCCESS_CODE_RESET, 0, 0);
        run_phase(8'($urandom), 0, 0);
        settle_pipeline();

        if (fail_count == 0) begin
            $display("uart_angle_response_unwrapper_core: match");
        end else begin
            $display("uart_angle_response_unwrapper_core: mismatch");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("uart_angle_response_unwrapper_core: mismatch");
        $finish;
    end

endmodule
